// ===== design/rprt_pkg.sv =====
// Package for the received packet range tracker.
// Holds the shared constants, the action and status codes and the sequencer state type.
// No dependencies.
package rprt_pkg;

    // Field width on the ports, fixed by the item format
    localparam int PN_W = 62;
    // Widest packet number the parameter range allows
    localparam int PN_MAX_W = 64;

    // Parameter defaults
    localparam int MAX_RANGES_DEF = 32;
    localparam int PN_BITS_DEF = 62;

    // Action codes
    localparam logic [1:0] ACT_RECORD = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_ACK    = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_DUP   = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_EMPTY = 2'd3;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_R_CHK,
        ST_M_CHK,
        ST_X_READ,
        ST_X_WRITE,
        ST_I_READ,
        ST_I_WRITE,
        ST_D_READ,
        ST_D_CHK,
        ST_A_EMIT,
        ST_PUT
    } st_t;

endpackage

// ===== design/rprt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Read data holds while the read enable is low. No dependencies.
module rprt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/received_packet_range_tracker_core.sv =====
// Received packet range tracker. Keeps up to MAX_RANGES disjoint packet-number intervals,
// sorted by number, in one RAM (one entry holds low and high bound), and runs one beat at
// a time through a sequencer that reads, modifies and writes back entries. A record beat
// walks the table from the top, one interval at a time; inserting a new interval then
// moves every entry above it up one slot, and a merge moves the entries above the
// removed slot down likewise. A delete-below beat drops every interval that lies wholly
// below the number, and each drop moves the rest of the table down one slot.
// An ack beat emits one result beat per cycle while the output is not stalled, one per
// interval, highest first, after a RAM read. Every record and delete beat answers with
// one result; an unused action code is dropped with no result. in_stall is high while
// a beat is in progress; results leave through an output register so a new beat can be
// taken while the last result waits. No clearing pass is needed.
module received_packet_range_tracker_core
    import rprt_pkg::*;
#(
    parameter int MAX_RANGES = rprt_pkg::MAX_RANGES_DEF,
    parameter int PN_BITS    = rprt_pkg::PN_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                action,
    input  logic [rprt_pkg::PN_W-1:0] packet_number,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                status,
    output logic [rprt_pkg::PN_W-1:0] range_start,
    output logic [rprt_pkg::PN_W-1:0] range_end,
    output logic                      last
);

    localparam int IDX_W = $clog2(MAX_RANGES);
    localparam int CNT_W = $clog2(MAX_RANGES + 1);
    localparam int ENT_W = 2 * PN_BITS;
    localparam logic [PN_BITS-1:0] PN_MASK = {PN_BITS{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RANGES);

    st_t state_reg, state_next;
    logic [PN_BITS-1:0] pn_reg, pn_next;
    logic [PN_BITS-1:0] floor_reg, floor_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]   i_reg, i_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [IDX_W-1:0]   tgt_reg, tgt_next;
    logic [PN_BITS-1:0] cur_lo_reg, cur_lo_next;
    logic [PN_BITS-1:0] cur_hi_reg, cur_hi_next;
    logic [1:0]         pend_reg, pend_next;
    logic               from_del_reg, from_del_next;

    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            status_reg, status_next;
    logic [PN_W-1:0]       start_reg, start_next;
    logic [PN_W-1:0]       end_reg, end_next;
    logic                  last_reg, last_next;

    // RAM port signals
    logic             ram_we, ram_re;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    logic [ENT_W-1:0] ram_wdata, ram_rdata;

    logic [PN_MAX_W-1:0] pin_ext, rlo_ext, rhi_ext;
    logic [PN_BITS-1:0]  p_in, rlo, rhi;
    logic                can_put;

    rprt_ram #(
        .WIDTH(ENT_W),
        .DEPTH(MAX_RANGES)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Field views and width adaption
    assign pin_ext = PN_MAX_W'(packet_number);
    assign p_in    = pin_ext[PN_BITS-1:0];
    assign rlo     = ram_rdata[ENT_W-1:PN_BITS];
    assign rhi     = ram_rdata[PN_BITS-1:0];
    assign rlo_ext = PN_MAX_W'(rlo);
    assign rhi_ext = PN_MAX_W'(rhi);
    assign can_put = !out_valid_reg || !out_stall;

    // State and payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            floor_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            floor_reg     <= floor_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pn_reg       <= pn_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        tgt_reg      <= tgt_next;
        cur_lo_reg   <= cur_lo_next;
        cur_hi_reg   <= cur_hi_next;
        pend_reg     <= pend_next;
        from_del_reg <= from_del_next;
        status_reg   <= status_next;
        start_reg    <= start_next;
        end_reg      <= end_next;
        last_reg     <= last_next;
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        pn_next       = pn_reg;
        floor_next    = floor_reg;
        cnt_next      = cnt_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        tgt_next      = tgt_reg;
        cur_lo_next   = cur_lo_reg;
        cur_hi_next   = cur_hi_reg;
        pend_next     = pend_reg;
        from_del_next = from_del_reg;
        status_next   = status_reg;
        start_next    = start_reg;
        end_next      = end_reg;
        last_next     = last_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;
        ram_re        = 1'b0;
        ram_raddr     = '0;

        // Output register drains when taken
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    pn_next = p_in;
                    case (action)
                        ACT_RECORD:
                        begin
                            if (cnt_reg == '0)
                            begin
                                tgt_next   = '0;
                                j_next     = '0;
                                state_next = ST_I_READ;
                            end
                            else
                            begin
                                i_next     = IDX_W'(cnt_reg - CNT_W'(1));
                                ram_re     = 1'b1;
                                ram_raddr  = IDX_W'(cnt_reg - CNT_W'(1));
                                state_next = ST_R_CHK;
                            end
                        end
                        ACT_DELETE:
                        begin
                            pend_next = STAT_OK;
                            if (p_in <= floor_reg)
                            begin
                                state_next = ST_PUT;
                            end
                            else
                            begin
                                floor_next = p_in;
                                state_next = ST_D_READ;
                            end
                        end
                        ACT_ACK:
                        begin
                            if (cnt_reg == '0)
                            begin
                                pend_next  = STAT_EMPTY;
                                state_next = ST_PUT;
                            end
                            else
                            begin
                                i_next     = IDX_W'(cnt_reg - CNT_W'(1));
                                ram_re     = 1'b1;
                                ram_raddr  = IDX_W'(cnt_reg - CNT_W'(1));
                                state_next = ST_A_EMIT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // Walk down from the top interval
            ST_R_CHK:
            begin
                pend_next = STAT_OK;
                if (rlo <= pn_reg && pn_reg <= rhi)
                begin
                    pend_next  = STAT_DUP;
                    state_next = ST_PUT;
                end
                else if ((pn_reg != '0 && rhi == pn_reg - PN_BITS'(1)) ||
                         (pn_reg != PN_MASK && rlo == pn_reg + PN_BITS'(1)))
                begin
                    // Extend this interval up or down
                    if (pn_reg != '0 && rhi == pn_reg - PN_BITS'(1))
                    begin
                        cur_lo_next = rlo;
                        cur_hi_next = pn_reg;
                    end
                    else
                    begin
                        cur_lo_next = pn_reg;
                        cur_hi_next = rhi;
                    end
                    ram_we    = 1'b1;
                    ram_waddr = i_reg;
                    ram_wdata = {cur_lo_next, cur_hi_next};
                    if (i_reg != '0)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = i_reg - IDX_W'(1);
                        state_next = ST_M_CHK;
                    end
                    else
                    begin
                        state_next = ST_PUT;
                    end
                end
                else if (pn_reg > rhi || i_reg == '0)
                begin
                    // New single-number interval above this one, or at the bottom
                    if (cnt_reg >= CNT_MAX)
                    begin
                        pend_next  = STAT_FULL;
                        state_next = ST_PUT;
                    end
                    else
                    begin
                        tgt_next   = (pn_reg > rhi) ? i_reg + IDX_W'(1) : '0;
                        j_next     = IDX_W'(cnt_reg);
                        state_next = ST_I_READ;
                    end
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = i_reg - IDX_W'(1);
                    i_next    = i_reg - IDX_W'(1);
                end
            end

            // Merge with the lower neighbour when they touch
            ST_M_CHK:
            begin
                if (rhi != PN_MASK && rhi + PN_BITS'(1) == cur_lo_reg)
                begin
                    ram_we        = 1'b1;
                    ram_waddr     = i_reg - IDX_W'(1);
                    ram_wdata     = {rlo, cur_hi_reg};
                    j_next        = i_reg;
                    from_del_next = 1'b0;
                    state_next    = ST_X_READ;
                end
                else
                begin
                    state_next = ST_PUT;
                end
            end

            // Remove slot j: move entries above it down by one
            ST_X_READ:
            begin
                if (CNT_W'(j_reg) + CNT_W'(1) < cnt_reg)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = j_reg + IDX_W'(1);
                    state_next = ST_X_WRITE;
                end
                else
                begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = from_del_reg ? ST_D_READ : ST_PUT;
                end
            end

            ST_X_WRITE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = j_reg;
                ram_wdata  = ram_rdata;
                j_next     = j_reg + IDX_W'(1);
                state_next = ST_X_READ;
            end

            // Insert at tgt: move entries from tgt upward by one, top first
            ST_I_READ:
            begin
                if (j_reg > tgt_reg)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = j_reg - IDX_W'(1);
                    state_next = ST_I_WRITE;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = tgt_reg;
                    ram_wdata  = {pn_reg, pn_reg};
                    cnt_next   = cnt_reg + CNT_W'(1);
                    pend_next  = STAT_OK;
                    state_next = ST_PUT;
                end
            end

            ST_I_WRITE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = j_reg;
                ram_wdata  = ram_rdata;
                j_next     = j_reg - IDX_W'(1);
                state_next = ST_I_READ;
            end

            // Delete-below: look at the lowest interval
            ST_D_READ:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_PUT;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = '0;
                    state_next = ST_D_CHK;
                end
            end

            ST_D_CHK:
            begin
                if (rhi < pn_reg)
                begin
                    j_next        = '0;
                    from_del_next = 1'b1;
                    state_next    = ST_X_READ;
                end
                else
                begin
                    if (pn_reg > rlo)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = '0;
                        ram_wdata = {pn_reg, rhi};
                    end
                    state_next = ST_PUT;
                end
            end

            // Ack: one result beat per interval, highest first
            ST_A_EMIT:
            begin
                if (can_put)
                begin
                    out_valid_next = 1'b1;
                    status_next    = STAT_OK;
                    start_next     = rlo_ext[PN_W-1:0];
                    end_next       = rhi_ext[PN_W-1:0];
                    last_next      = (i_reg == '0);
                    if (i_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = i_reg - IDX_W'(1);
                        i_next    = i_reg - IDX_W'(1);
                    end
                end
            end

            // Single result beat for record, delete-below and an ack on an empty table
            ST_PUT:
            begin
                if (can_put)
                begin
                    out_valid_next = 1'b1;
                    status_next    = pend_reg;
                    start_next     = '0;
                    end_next       = '0;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign range_start = start_reg;
    assign range_end   = end_reg;
    assign last        = last_reg;

endmodule

// ===== design/rprt_checker.sv =====
// Port-level checks for the received packet range tracker, and the bind that attaches them.
// Depends on rprt_pkg and received_packet_range_tracker_core.
module rprt_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic [1:0]                action,
    input logic [rprt_pkg::PN_W-1:0] packet_number,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [1:0]                status,
    input logic [rprt_pkg::PN_W-1:0] range_start,
    input logic [rprt_pkg::PN_W-1:0] range_end,
    input logic                      last
);
    import rprt_pkg::*;

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(last)
            && $stable(range_start) && $stable(range_end))
        else $error("stalled result beat changed");

    // A valid action keeps the block busy for at least the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (action == ACT_RECORD || action == ACT_DELETE
            || action == ACT_ACK) |=> in_stall)
        else $error("block took a second beat straight after a valid action");

    // Anything but an ok status is a single, final result beat
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STAT_OK |-> last)
        else $error("non-ok status without last");

    // Results with a non-ok status carry zero ranges
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STAT_OK |-> range_start == '0 && range_end == '0)
        else $error("non-ok status with range data");

endmodule

bind received_packet_range_tracker_core rprt_checker u_rprt_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for received_packet_range_tracker_core.
// A queue-fed driver, a monitor and a behavioural interval table predict every result beat.
// Depends on rprt_pkg and the core only.
module tb_top;
    import rprt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NR = MAX_RANGES_DEF;
    localparam logic [PN_W-1:0] PN_TOP = {PN_W{1'b1}};

    typedef struct packed {
        logic [1:0]      act;
        logic [PN_W-1:0] pn;
    } op_t;

    typedef struct packed {
        logic [1:0]      st;
        logic [PN_W-1:0] lo;
        logic [PN_W-1:0] hi;
        logic            lst;
    } ack_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] action = ACT_RECORD;
    logic [PN_W-1:0] packet_number = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] status;
    logic [PN_W-1:0] range_start;
    logic [PN_W-1:0] range_end;
    logic last;

    op_t  pending_ops[$];
    ack_t expected_beats[$];
    int   mismatches = 0;
    int   hold_cycles = 0;
    bit   long_hold = 1'b0;
    bit   long_hold_q = 1'b0;
    bit   sender_pause = 1'b0;
    int   gap_left = 0;
    int   burst_left = 0;

    // Stall seen at the last rising edge, so the driver knows if its beat went in
    logic in_stall_q = 1'b0;

    // Shadow interval table
    logic [PN_W-1:0] tab_lo[NR];
    logic [PN_W-1:0] tab_hi[NR];
    int              tab_n = 0;
    logic [PN_W-1:0] floor_pn = '0;

    received_packet_range_tracker_core uut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .packet_number(packet_number), .out_valid(out_valid),
        .out_stall(out_stall), .status(status), .range_start(range_start),
        .range_end(range_end), .last(last)
    );

    always #4 clk = ~clk;

    function automatic void drop_slot(int idx);
        for (int j = idx; j + 1 < tab_n; j++)
        begin
            tab_lo[j] = tab_lo[j + 1];
            tab_hi[j] = tab_hi[j + 1];
        end
        tab_n--;
    endfunction

    function automatic logic [1:0] add_slot(int idx, logic [PN_W-1:0] p);
        if (tab_n >= NR)
            return STAT_FULL;
        for (int j = tab_n; j > idx; j--)
        begin
            tab_lo[j] = tab_lo[j - 1];
            tab_hi[j] = tab_hi[j - 1];
        end
        tab_lo[idx] = p;
        tab_hi[idx] = p;
        tab_n++;
        return STAT_OK;
    endfunction

    function automatic logic [1:0] note_packet(logic [PN_W-1:0] p);
        bit grew;
        for (int i = tab_n - 1; i >= 0; i--)
        begin
            grew = 1'b0;
            if (tab_lo[i] <= p && p <= tab_hi[i])
                return STAT_DUP;
            if (p != 0 && tab_hi[i] == p - 1)
            begin
                tab_hi[i] = p;
                grew = 1'b1;
            end
            else if (p != PN_TOP && tab_lo[i] == p + 1)
            begin
                tab_lo[i] = p;
                grew = 1'b1;
            end
            if (grew)
            begin
                if (i > 0 && tab_hi[i - 1] < PN_TOP && tab_hi[i - 1] + 1 == tab_lo[i])
                begin
                    tab_hi[i - 1] = tab_hi[i];
                    drop_slot(i);
                end
                return STAT_OK;
            end
            if (p > tab_hi[i])
                return add_slot(i + 1, p);
        end
        return add_slot(0, p);
    endfunction

    // Work out the result beats of one accepted op
    function automatic void predict_ranges(op_t op);
        ack_t r;
        r = '{st: STAT_OK, lo: '0, hi: '0, lst: 1'b1};
        case (op.act)
            ACT_RECORD:
            begin
                r.st = note_packet(op.pn);
                expected_beats.push_back(r);
            end
            ACT_DELETE:
            begin
                if (op.pn > floor_pn)
                begin
                    floor_pn = op.pn;
                    while (tab_n > 0 && tab_hi[0] < op.pn)
                        drop_slot(0);
                    if (tab_n > 0 && op.pn > tab_lo[0])
                        tab_lo[0] = op.pn;
                end
                expected_beats.push_back(r);
            end
            ACT_ACK:
            begin
                if (tab_n == 0)
                begin
                    r.st = STAT_EMPTY;
                    expected_beats.push_back(r);
                end
                else
                    for (int i = tab_n - 1; i >= 0; i--)
                    begin
                        r.lo = tab_lo[i];
                        r.hi = tab_hi[i];
                        r.lst = (i == 0);
                        expected_beats.push_back(r);
                    end
            end
            default: ;
        endcase
    endfunction

    function automatic logic [PN_W-1:0] rnd_pn();
        return PN_W'({$urandom, $urandom});
    endfunction

    // Driver: bursts and gaps, changes on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!(in_valid && in_stall_q))
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_ops.size() > 0 && !sender_pause)
                begin
                    in_valid <= 1'b1;
                    action <= pending_ops[0].act;
                    packet_number <= pending_ops[0].pn;
                    void'(pending_ops.pop_front());
                    if (burst_left > 0)
                        burst_left <= burst_left - 1;
                    else
                    begin
                        burst_left <= $urandom_range(0, 8);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        in_stall_q <= in_stall;
        if (rst_n && in_valid && !in_stall)
            predict_ranges('{act: action, pn: packet_number});
    end

    // Receiver stall pattern, with long hold-offs counted here
    always @(negedge clk)
    begin
        long_hold_q <= long_hold;
        if (long_hold && !long_hold_q)
        begin
            hold_cycles <= 400;
            out_stall <= 1'b1;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 3) == 0);
    end

    // Monitor
    always @(posedge clk)
    begin
        ack_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat st=%0d %0h..%0h last=%0b",
                             status, range_start, range_end, last);
            end
            else
            begin
                e = expected_beats.pop_front();
                if (e.st !== status || e.lo !== range_start || e.hi !== range_end
                    || e.lst !== last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp st=%0d %0h..%0h l=%0b got st=%0d %0h..%0h l=%0b",
                                 e.st, e.lo, e.hi, e.lst, status, range_start,
                                 range_end, last);
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("[received_packet_range_tracker_core] ERROR");
        $finish;
    end

    task automatic push_op(logic [1:0] a, logic [PN_W-1:0] p);
        pending_ops.push_back('{act: a, pn: p});
    endtask

    task automatic wait_drained();
        while (pending_ops.size() > 0 || in_valid || expected_beats.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [PN_W-1:0] base;
        int k;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty ack, limits, merge, duplicate, floor cases, unused action
        push_op(ACT_ACK, '0);
        push_op(ACT_RECORD, '0);
        push_op(ACT_RECORD, PN_TOP);
        push_op(ACT_RECORD, PN_TOP - 1);
        push_op(ACT_RECORD, 2);
        push_op(ACT_RECORD, 1);
        push_op(ACT_RECORD, 1);
        push_op(ACT_RECORD, 10);
        push_op(ACT_RECORD, 12);
        push_op(ACT_RECORD, 11);
        push_op(ACT_ACK, '0);
        push_op(2'd3, 62'h2AAA_AAAA_AAAA_AAAA);
        push_op(ACT_DELETE, 2);
        push_op(ACT_DELETE, 1);
        push_op(ACT_RECORD, 0);
        push_op(ACT_DELETE, 11);
        push_op(ACT_ACK, '0);
        push_op(ACT_DELETE, PN_TOP);
        push_op(ACT_ACK, '0);
        wait_drained();

        // Fill past capacity with spaced numbers while the receiver holds off
        long_hold = 1'b1;
        for (int i = 0; i < NR + 2; i++)
            push_op(ACT_RECORD, 62'h1000 + 4 * i);
        push_op(ACT_RECORD, 62'h1001);
        push_op(ACT_RECORD, 62'h1003);
        push_op(ACT_ACK, '0);
        wait_drained();
        long_hold = 1'b0;

        // Sender pauses once every result is in
        sender_pause = 1'b1;
        repeat (20) @(posedge clk);
        sender_pause = 1'b0;

        // Random: clustered numbers to exercise merges, plus noise
        for (int n = 0; n < 50; n++)
        begin
            base = ($urandom_range(0, 9) == 0) ? rnd_pn() : 62'h1000;
            k = $urandom_range(0, 19);
            if (k < 12)
                push_op(ACT_RECORD, base + $urandom_range(0, 150));
            else if (k < 15)
                push_op(ACT_DELETE, base + $urandom_range(0, 60));
            else if (k < 19)
                push_op(ACT_ACK, rnd_pn());
            else
                push_op(2'd3, rnd_pn());
        end
        wait_drained();
        repeat (200) @(posedge clk);

        if (mismatches == 0 && expected_beats.size() == 0)
            $display("[received_packet_range_tracker_core] OK");
        else
            $display("[received_packet_range_tracker_core] ERROR");
        $finish;
    end
endmodule
